// File: rtl/core/cmf_pkg.sv
// Package for the CR-LF multi-line message framer.
// Holds payload types, character codes, event codes, register indexes and register reset values.
// No dependencies.
`default_nettype none

package cmf_pkg;

  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_CR = 8'h0d;

  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_DONE       = 3'd1;
  localparam logic [2:0] EV_BLANK      = 3'd2;
  localparam logic [2:0] EV_IDLE_LONG  = 3'd3;
  localparam logic [2:0] EV_MANY_LINES = 3'd4;
  localparam logic [2:0] EV_FORMAT     = 3'd5;
  localparam logic [2:0] EV_LINE_LONG  = 3'd6;
  localparam logic [2:0] EV_MSG_LONG   = 3'd7;

  localparam logic [1:0] REG_MAX_LINES       = 2'd0;
  localparam logic [1:0] REG_MAX_LINE_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_MSG_LENGTH  = 2'd2;

  localparam logic [3:0] MAX_LINES_RST       = 4'd8;
  localparam logic [7:0] MAX_LINE_LENGTH_RST = 8'd42;
  localparam logic [8:0] MAX_MSG_LENGTH_RST  = 9'd312;

  localparam logic [3:0] LINES_SAT = 4'd15;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_beat_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       store_byte;
    logic [8:0] store_position;
    logic [2:0] event_res;
    logic [8:0] message_length;
    logic [3:0] line_count;
  } res_beat_t;

endpackage

`default_nettype wire

// File: rtl/core/cmf_rx_if.sv
// Input channel of the framer: one received byte per beat.
// Depends on cmf_pkg.
`default_nettype none

interface cmf_rx_if;
  logic              valid;
  logic              ready;
  cmf_pkg::rx_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cmf_res_if.sv
// Result channel of the framer: one framing decision per beat.
// Depends on cmf_pkg.
`default_nettype none

interface cmf_res_if;
  logic               valid;
  logic               ready;
  cmf_pkg::res_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/crlf_multiline_message_framer.sv
// Top level of the CR-LF multi-line message framer.
// Depends on cmf_pkg, cmf_rx_if and cmf_res_if.
//
//   channel  dir  beat contents
//   rx       in   rx_byte
//   res      out  data_byte, store_byte, store_position, event_res,
//                 message_length, line_count
//   cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// One beat per cycle while the skid register is empty.
// Framing state updates in the cycle a byte is taken; result goes to an
// output register backed by a one-entry skid register.
// rx.ready drops only while the skid register holds a beat.
// rst (synchronous) sets idle mode, clears counters and loads register defaults.
`default_nettype none

module crlf_multiline_message_framer (
  input  wire logic       clk,
  input  wire logic       rst,
  cmf_rx_if.sink          rx,
  cmf_res_if.source       res,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data
);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COLLECT = 2'd1,
    MODE_DISCARD = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  mode_t      mode, mode_next;
  logic [7:0] chars_in_line, chars_next;
  logic [3:0] lines_in_message, lines_next;
  logic [8:0] stored_length, stored_next;
  logic [7:0] last_byte, last_next;

  logic [3:0] max_lines;
  logic [7:0] max_line_length;
  logic [8:0] max_message_length;

  cmf_pkg::res_beat_t out_beat, skid_beat, new_beat;
  logic               out_valid, skid_valid;
  logic               acc, out_fire;

  logic [7:0] b;
  logic [7:0] chars_inc;
  logic [8:0] stored_inc;
  logic [4:0] lines_inc;
  logic       is_lf, long_line;
  logic       store;
  logic [8:0] pos;
  logic [2:0] ev;

  assign acc      = rx.valid && rx.ready;
  assign out_fire = out_valid && res.ready;
  assign rx.ready = !skid_valid;
  assign res.valid = out_valid;
  assign res.data  = out_beat;

  assign b          = rx.data.rx_byte;
  assign chars_inc  = chars_in_line + 8'd1;
  assign stored_inc = stored_length + 9'd1;
  assign lines_inc  = {1'b0, lines_in_message} + 5'd1;
  assign is_lf      = (b == cmf_pkg::CHAR_LF);
  assign long_line  = (chars_inc > max_line_length);

  always_comb begin
    mode_next   = mode;
    chars_next  = chars_inc;
    lines_next  = lines_in_message;
    stored_next = stored_length;
    last_next   = b;
    store       = 1'b0;
    pos         = '0;
    ev          = cmf_pkg::EV_NONE;
    case (mode)
      MODE_IDLE: begin
        store       = 1'b1;
        pos         = stored_length;
        stored_next = stored_inc;
        if (is_lf) begin
          chars_next = '0;
          if (chars_inc > 8'd2) begin
            lines_next = 4'd1;
            mode_next  = MODE_COLLECT;
          end else begin
            ev          = cmf_pkg::EV_BLANK;
            stored_next = '0;
          end
        end else if (long_line) begin
          ev          = cmf_pkg::EV_IDLE_LONG;
          chars_next  = '0;
          stored_next = '0;
        end
      end
      MODE_COLLECT: begin
        store       = 1'b1;
        pos         = stored_length;
        stored_next = stored_inc;
        if (is_lf) begin
          chars_next = '0;
          if (chars_inc > 8'd2) begin
            if (lines_inc > {1'b0, max_lines}) begin
              ev         = cmf_pkg::EV_MANY_LINES;
              lines_next = lines_inc[4] ? cmf_pkg::LINES_SAT : lines_inc[3:0];
              mode_next  = MODE_DISCARD;
            end else begin
              lines_next = lines_inc[3:0];
            end
          end else if (chars_inc == 8'd2 && last_byte == cmf_pkg::CHAR_CR) begin
            ev          = cmf_pkg::EV_DONE;
            stored_next = '0;
            mode_next   = MODE_IDLE;
          end else begin
            ev        = cmf_pkg::EV_FORMAT;
            mode_next = MODE_DISCARD;
          end
        end else if (long_line) begin
          ev         = cmf_pkg::EV_LINE_LONG;
          chars_next = '0;
          mode_next  = MODE_DISCARD;
        end else if (stored_inc >= max_message_length) begin
          ev         = cmf_pkg::EV_MSG_LONG;
          chars_next = '0;
          mode_next  = MODE_DISCARD;
        end
      end
      MODE_DISCARD: begin
        if (is_lf) begin
          if (chars_inc > 8'd2) begin
            chars_next = '0;
          end else if (chars_inc == 8'd2 && last_byte == cmf_pkg::CHAR_CR) begin
            chars_next  = '0;
            stored_next = '0;
            mode_next   = MODE_IDLE;
          end
        end
      end
      default: begin
        chars_next  = '0;
        stored_next = '0;
        last_next   = last_byte;
        mode_next   = MODE_IDLE;
      end
    endcase
    new_beat.data_byte      = b;
    new_beat.store_byte     = store;
    new_beat.store_position = pos;
    new_beat.event_res      = ev;
    new_beat.message_length = stored_next;
    new_beat.line_count     = lines_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_IDLE;
      chars_in_line      <= '0;
      lines_in_message   <= '0;
      stored_length      <= '0;
      last_byte          <= '0;
      max_lines          <= cmf_pkg::MAX_LINES_RST;
      max_line_length    <= cmf_pkg::MAX_LINE_LENGTH_RST;
      max_message_length <= cmf_pkg::MAX_MSG_LENGTH_RST;
      out_valid          <= 1'b0;
      skid_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cmf_pkg::REG_MAX_LINES:       max_lines          <= cfg_data[3:0];
          cmf_pkg::REG_MAX_LINE_LENGTH: max_line_length    <= cfg_data[7:0];
          cmf_pkg::REG_MAX_MSG_LENGTH:  max_message_length <= cfg_data;
          default: ;
        endcase
      end
      if (acc) begin
        mode             <= mode_next;
        chars_in_line    <= chars_next;
        lines_in_message <= lines_next;
        stored_length    <= stored_next;
        last_byte        <= last_next;
      end
      if (!out_valid || out_fire) begin
        if (skid_valid) begin
          out_beat   <= skid_beat;
          out_valid  <= 1'b1;
          skid_valid <= acc;
          if (acc) begin
            skid_beat <= new_beat;
          end
        end else begin
          out_valid <= acc;
          if (acc) begin
            out_beat <= new_beat;
          end
        end
      end else if (acc) begin
        skid_beat  <= new_beat;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
